/* rtl/cce_pkg.sv */
// shared types, character constants and escape letter lookup for the escape encoder
`default_nettype none

package cce_pkg;

    localparam int MaxResults = 6;
    localparam int CountW     = $clog2(MaxResults + 1);
    localparam int BodyLen    = 4;

    localparam logic [7:0] CharCr    = 8'd13;
    localparam logic [7:0] CharLf    = 8'd10;
    localparam logic [7:0] CharBsl   = 8'd92;
    localparam logic [7:0] CharZero  = 8'd48;
    localparam logic [7:0] CharN     = 8'd110;
    localparam logic [7:0] CharR     = 8'd114;
    localparam logic [7:0] CharSpace = 8'd32;
    localparam logic [7:0] CharNone  = 8'd0;

    typedef struct packed {
        logic [7:0] in_char;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       string_done;
    } out_item_t;

    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [CountW-1:0]          count;
    } esc_seq_t;

    // letter for the named control codes, CharNone for the rest
    function automatic logic [7:0] esc_letter(input logic [7:0] c);
        logic [7:0] letter;
        unique case (c)
            8'd7:    letter = 8'd97;   // a
            8'd8:    letter = 8'd98;   // b
            8'd27:   letter = 8'd101;  // e
            8'd12:   letter = 8'd102;  // f
            8'd13:   letter = 8'd114;  // r
            8'd9:    letter = 8'd116;  // t
            8'd11:   letter = 8'd118;  // v
            default: letter = CharNone;
        endcase
        return letter;
    endfunction

endpackage

`default_nettype wire

/* rtl/cce_encode.sv */
// expands one input byte into its escape sequence, given the held cr flag
`default_nettype none

module cce_encode (
    input  var cce_pkg::in_item_t item,
    input  var logic              held,
    output var cce_pkg::esc_seq_t seq,
    output var logic              held_next
);
    import cce_pkg::*;

    logic [BodyLen-1:0][7:0] body;
    logic [CountW-1:0]       body_cnt;
    logic [7:0]              letter;
    logic [7:0]              c;

    assign c      = item.in_char;
    assign letter = esc_letter(c);

    // encoding of the byte itself
    always_comb begin
        body     = '0;
        body_cnt = '0;
        held_next = 1'b0;
        if (c == CharCr && !item.string_end) begin
            held_next = 1'b1;
        end else if (c >= CharSpace) begin
            body[0]  = c;
            body_cnt = CountW'(1);
        end else if (letter != CharNone) begin
            body[0]  = CharBsl;
            body[1]  = letter;
            body_cnt = CountW'(2);
        end else if (c >= 8'd8) begin
            body[0]  = CharBsl;
            body[1]  = CharZero;
            body[2]  = CharZero + {3'b000, c[7:3]};
            body[3]  = CharZero + {5'b00000, c[2:0]};
            body_cnt = CountW'(4);
        end else begin
            body[0]  = CharBsl;
            body[1]  = CharZero;
            body[2]  = CharZero + {5'b00000, c[2:0]};
            body_cnt = CountW'(3);
        end
    end

    // prefix for a held cr, which swallows a following lf
    always_comb begin
        seq = '0;
        if (held && c == CharLf) begin
            seq.bytes[0] = CharBsl;
            seq.bytes[1] = CharN;
            seq.count    = CountW'(2);
        end else if (held) begin
            seq.bytes[0] = CharBsl;
            seq.bytes[1] = CharR;
            for (int i = 0; i < BodyLen; i++) begin
                seq.bytes[i + 2] = body[i];
            end
            seq.count = body_cnt + CountW'(2);
        end else begin
            for (int i = 0; i < BodyLen; i++) begin
                seq.bytes[i] = body[i];
            end
            seq.count = body_cnt;
        end
    end

endmodule

`default_nettype wire

/* rtl/control_char_escape_encoder_core.sv */
// Control character escape encoder: takes one byte per item and gives escaped text, one
// byte per result item. An item is decoded in the cycle it is accepted into a sequence
// register of up to six bytes, which is shifted into the output register one byte a cycle
// while the output is not stalled; a plain printable byte goes through at one item per
// cycle under the same condition, and the next item is taken in the cycle the last byte
// of the current one moves to the output. A CR that is not the final byte of a string
// yields nothing at first and comes out with the next item, as backslash n when that
// item is an LF, otherwise as backslash r ahead of its encoding.
// run_last marks the final result of each item, string_done the final byte of a string.
`default_nettype none

module control_char_escape_encoder_core (
    input  var logic               aclk,
    input  var logic               aresetn,
    input  var logic               s_valid,
    output var logic               s_ready,
    input  var cce_pkg::in_item_t  s_item,
    output var logic               m_valid,
    input  var logic               m_ready,
    output var cce_pkg::out_item_t m_item
);
    import cce_pkg::*;

    esc_seq_t                   enc_seq;
    logic                       enc_held_next;
    logic [MaxResults-1:0][7:0] seq_reg, seq_next;
    logic [CountW-1:0]          rem_reg, rem_next;
    logic                       end_reg, end_next;
    logic                       held_reg, held_next;
    logic                       m_valid_reg, m_valid_next;
    out_item_t                  m_item_reg, m_item_next;
    logic                       out_free;
    logic                       moving;
    logic                       s_accept;

    cce_encode u_encode (
        .item      (s_item),
        .held      (held_reg),
        .seq       (enc_seq),
        .held_next (enc_held_next)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign moving   = (rem_reg != '0) && out_free;
    assign s_ready  = (rem_reg == '0) || (moving && rem_reg == CountW'(1));
    assign s_accept = s_valid && s_ready;

    always_comb begin
        seq_next  = seq_reg;
        rem_next  = rem_reg;
        end_next  = end_reg;
        held_next = held_reg;
        if (moving) begin
            seq_next = {8'h00, seq_reg[MaxResults-1:1]};
            rem_next = rem_reg - CountW'(1);
        end
        if (s_accept) begin
            seq_next  = enc_seq.bytes;
            rem_next  = enc_seq.count;
            end_next  = s_item.string_end;
            held_next = enc_held_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (out_free) begin
            m_valid_next            = moving;
            m_item_next.out_char    = seq_reg[0];
            m_item_next.run_last    = (rem_reg == CountW'(1));
            m_item_next.string_done = (rem_reg == CountW'(1)) && end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            held_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rem_reg     <= rem_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg    <= seq_next;
        end_reg    <= end_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // no new item while more than one byte of the current one is left
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg > CountW'(1) |-> !s_ready)
        else $error("input ready while sequence still busy");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= CountW'(MaxResults))
        else $error("sequence count out of range");

    a_hold_from_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(held_reg) |-> $past(s_item.in_char) == CharCr && !$past(s_item.string_end))
        else $error("cr held without a cr item");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.string_done |-> m_item_reg.run_last)
        else $error("string end flagged on a non-final byte");

endmodule

`default_nettype wire
